// ----- design/clr_pkg.sv -----
`default_nettype none
package clr_pkg;

  localparam int COORD_W = 16;
  localparam int SPAN_W  = 6;
  localparam int ERR_W   = 10;
  localparam int CNT_W   = 7;

  typedef enum logic [1:0] {
    CFG_SCREEN_WIDTH  = 2'd0,
    CFG_SCREEN_HEIGHT = 2'd1,
    CFG_DRAW_COLOR    = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    WALK_IDLE,
    WALK_LOAD,
    WALK_RUN
  } walk_state_t;

  typedef struct packed {
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
  } segment_t;

  typedef struct packed {
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic               visible;
    logic [6:0]         visible_count;
    logic [31:0]        pixel_color;
    logic               too_long;
    logic               last_pixel;
  } pixel_t;

  typedef struct packed {
    logic                      too_long;
    logic                      xmajor;
    logic                      minor_up;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [SPAN_W-1:0]         span;
    logic signed [ERR_W-1:0]   err;
    logic signed [ERR_W-1:0]   inc_n;
    logic signed [ERR_W-1:0]   inc_c;
  } desc_t;

endpackage
`default_nettype wire

// ----- design/clr_front.sv -----
`default_nettype none
module clr_front #(
  parameter int MAX_SPAN = 63
) (
  input  wire clr_pkg::segment_t segment,
  output clr_pkg::desc_t         desc
);

  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic [16:0]        adx;
  logic [16:0]        ady;
  logic               xmajor;
  logic [16:0]        span_full;
  logic               fwd;
  logic [5:0]         maj;
  logic [5:0]         mn;
  logic signed [9:0]  maj_s;
  logic signed [9:0]  mn_s;

  always_comb begin
    dx        = 17'(segment.end_x) - 17'(segment.start_x);
    dy        = 17'(segment.end_y) - 17'(segment.start_y);
    adx       = dx[16] ? 17'(-dx) : 17'(dx);
    ady       = dy[16] ? 17'(-dy) : 17'(dy);
    xmajor    = ady <= adx;
    span_full = xmajor ? adx : ady;
    fwd       = xmajor ? !dx[16] : !dy[16];
    maj       = span_full[5:0];
    mn        = xmajor ? ady[5:0] : adx[5:0];
    maj_s     = $signed({4'b0000, maj});
    mn_s      = $signed({4'b0000, mn});

    desc.too_long = span_full > 17'(MAX_SPAN);
    desc.xmajor   = xmajor;
    desc.minor_up = (dx[16] && dy[16]) || (!dx[16] && dx != 17'sd0 &&
                                           !dy[16] && dy != 17'sd0);
    desc.x        = fwd ? segment.start_x : segment.end_x;
    desc.y        = fwd ? segment.start_y : segment.end_y;
    desc.span     = maj;
    desc.err      = (mn_s <<< 1) - maj_s;
    desc.inc_n    = mn_s <<< 1;
    desc.inc_c    = (mn_s - maj_s) <<< 1;
  end

endmodule
`default_nettype wire

// ----- design/clr_queue.sv -----
`default_nettype none
module clr_queue #(
  parameter int DEPTH = 2
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  input  wire clr_pkg::desc_t  wr_data,
  input  wire                  pop,
  output clr_pkg::desc_t       rd_data,
  output logic                 full,
  output logic                 empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  clr_pkg::desc_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full  = fill == CNT_W'(DEPTH);
  assign empty = fill == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
    if (pop) begin
      rd_data <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/clr_walker.sv -----
`default_nettype none
module clr_walker (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  q_empty,
  input  wire clr_pkg::desc_t  q_data,
  output logic                 q_pop,
  input  wire [14:0]           screen_width,
  input  wire [14:0]           screen_height,
  input  wire [31:0]           draw_color,
  output logic                 result_valid,
  output clr_pkg::pixel_t      result
);

  clr_pkg::walk_state_t state;
  clr_pkg::walk_state_t state_next;

  logic                 too_long;
  logic                 xmajor;
  logic                 minor_up;
  logic signed [15:0]   x;
  logic signed [15:0]   y;
  logic [5:0]           remain;
  logic signed [9:0]    err;
  logic signed [9:0]    inc_n;
  logic signed [9:0]    inc_c;
  logic [6:0]           cnt;

  logic                 emit;
  logic                 last;
  logic                 vis;
  logic                 take;
  logic signed [15:0]   dir;
  logic [6:0]           cnt_next;

  always_comb begin
    last     = too_long || remain == '0;
    vis      = !x[15] && x[14:0] < screen_width && !y[15] && y[14:0] < screen_height;
    cnt_next = cnt + 7'(vis);
    take     = xmajor ? !err[9] : (!err[9] && err != '0);
    dir      = minor_up ? 16'sd1 : -16'sd1;
  end

  always_comb begin
    state_next = state;
    case (state)
      clr_pkg::WALK_IDLE: if (!q_empty) state_next = clr_pkg::WALK_LOAD;
      clr_pkg::WALK_LOAD: state_next = clr_pkg::WALK_RUN;
      clr_pkg::WALK_RUN:  if (last) state_next = clr_pkg::WALK_IDLE;
      default:            state_next = clr_pkg::WALK_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    emit  = 1'b0;
    case (state)
      clr_pkg::WALK_IDLE: q_pop = !q_empty;
      clr_pkg::WALK_RUN:  emit  = 1'b1;
      default: begin
        q_pop = 1'b0;
        emit  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= clr_pkg::WALK_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (state == clr_pkg::WALK_LOAD) begin
      too_long <= q_data.too_long;
      xmajor   <= q_data.xmajor;
      minor_up <= q_data.minor_up;
      x        <= q_data.x;
      y        <= q_data.y;
      remain   <= q_data.span;
      err      <= q_data.err;
      inc_n    <= q_data.inc_n;
      inc_c    <= q_data.inc_c;
      cnt      <= '0;
    end else if (emit) begin
      cnt    <= cnt_next;
      remain <= remain - 1'b1;
      if (xmajor) begin
        x <= x + 16'sd1;
        if (take) y <= y + dir;
      end else begin
        y <= y + 16'sd1;
        if (take) x <= x + dir;
      end
      err <= take ? err + inc_c : err + inc_n;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (too_long) begin
        result <= '{pixel_x: '0, pixel_y: '0, visible: 1'b0, visible_count: '0,
                    pixel_color: '0, too_long: 1'b1, last_pixel: 1'b1};
      end else begin
        result <= '{pixel_x: x, pixel_y: y, visible: vis, visible_count: cnt_next,
                    pixel_color: draw_color, too_long: 1'b0, last_pixel: last};
      end
    end
  end

  a_too_long_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.too_long |-> result.last_pixel)
    else $error("rejected segment result without last_pixel");

  a_load_then_run: assert property (@(posedge clk) disable iff (rst)
    state == clr_pkg::WALK_LOAD |=> state == clr_pkg::WALK_RUN)
    else $error("walker did not start after load");

  a_burst_unbroken: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last_pixel |=> result_valid)
    else $error("gap inside a segment's pixel burst");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.visible_count <= 7'd64)
    else $error("visible count beyond segment length");

endmodule
`default_nettype wire

// ----- design/clipped_line_rasterizer_unit.sv -----
// The first pixel follows acceptance through the queue, the walker's idle
// and load states and the registered result output. A segment gives span+1
// result pixels in one unbroken burst; a rejected one gives a single result.
// busy is high while the segment queue is full. Results cannot be stalled.
// Synchronous reset restores the screen size and colour defaults and empties
// the queue and the walker.
`default_nettype none
module clipped_line_rasterizer_unit #(
  parameter int MAX_SPAN    = 63,
  parameter int QUEUE_DEPTH = 2
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   start,
  output logic                  busy,
  input  wire clr_pkg::segment_t segment,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire [1:0]             cfg_index,
  input  wire [31:0]            cfg_data,
  output logic                  result_valid,
  output clr_pkg::pixel_t       result
);

  logic [14:0]    screen_width;
  logic [14:0]    screen_height;
  logic [31:0]    draw_color;
  clr_pkg::desc_t front_desc;
  clr_pkg::desc_t q_data;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;
  logic           push;

  assign cfg_ready = 1'b1;
  assign busy      = q_full;
  assign push      = start && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= 15'd1920;
      screen_height <= 15'd1080;
      draw_color    <= 32'hFFFF_FFFF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        clr_pkg::CFG_SCREEN_WIDTH:  screen_width  <= cfg_data[14:0];
        clr_pkg::CFG_SCREEN_HEIGHT: screen_height <= cfg_data[14:0];
        clr_pkg::CFG_DRAW_COLOR:    draw_color    <= cfg_data;
        default: ;
      endcase
    end
  end

  clr_front #(
    .MAX_SPAN(MAX_SPAN)
  ) u_front (
    .segment(segment),
    .desc   (front_desc)
  );

  clr_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_data(front_desc),
    .pop    (q_pop),
    .rd_data(q_data),
    .full   (q_full),
    .empty  (q_empty)
  );

  clr_walker u_walker (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .screen_width (screen_width),
    .screen_height(screen_height),
    .draw_color   (draw_color),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule
`default_nettype wire

// ----- tb/clr_checker.sv -----
`timescale 1ns / 1ps
module clr_checker (
  input  wire               clk,
  input  wire               rst,
  input  wire               start,
  input  wire               busy,
  input  clr_pkg::segment_t segment,
  input  wire               cfg_valid,
  input  wire               cfg_ready,
  input  wire [1:0]         cfg_index,
  input  wire [31:0]        cfg_data,
  input  wire               result_valid,
  input  clr_pkg::pixel_t   result,
  output int                errors,
  output int                pending,
  output int                segments_seen,
  output int                pixels_seen,
  output int                rejects_seen
);

  localparam int SPAN_LIMIT = 63;
  localparam int PRINT_LIMIT = 40;

  logic [14:0]     width_reg;
  logic [14:0]     height_reg;
  logic [31:0]     color_reg;
  clr_pkg::pixel_t expected_pixels[$];

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic trace_segment(input clr_pkg::segment_t s);
    int x0, y0, x1, y1, dx, dy, adx, ady, span, step, err, x, y;
    bit xmajor, vis;
    int unsigned lit;
    clr_pkg::pixel_t p;
    x0 = s.start_x;
    y0 = s.start_y;
    x1 = s.end_x;
    y1 = s.end_y;
    dx = x1 - x0;
    dy = y1 - y0;
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    xmajor = ady <= adx;
    span = xmajor ? adx : ady;
    step = ((dx < 0 && dy < 0) || (dx > 0 && dy > 0)) ? 1 : -1;
    p = '0;
    if (span > SPAN_LIMIT) begin
      p.too_long = 1'b1;
      p.last_pixel = 1'b1;
      expected_pixels.push_back(p);
      rejects_seen++;
      return;
    end
    if (xmajor ? dx >= 0 : dy >= 0) begin
      x = x0;
      y = y0;
    end else begin
      x = x1;
      y = y1;
    end
    err = xmajor ? 2 * ady - adx : 2 * adx - ady;
    lit = 0;
    for (int i = 0; i <= span; i++) begin
      if (i > 0) begin
        if (xmajor) begin
          x++;
          if (err < 0) begin
            err += 2 * ady;
          end else begin
            y += step;
            err += 2 * (ady - adx);
          end
        end else begin
          y++;
          if (err <= 0) begin
            err += 2 * adx;
          end else begin
            x += step;
            err += 2 * (adx - ady);
          end
        end
      end
      vis = x >= 0 && x < int'(width_reg) && y >= 0 && y < int'(height_reg);
      if (vis) lit++;
      p.pixel_x = x[15:0];
      p.pixel_y = y[15:0];
      p.visible = vis;
      p.visible_count = lit[6:0];
      p.pixel_color = color_reg;
      p.too_long = 1'b0;
      p.last_pixel = (i == span);
      expected_pixels.push_back(p);
    end
  endtask

  always @(posedge clk) begin
    clr_pkg::pixel_t want;
    if (rst) begin
      width_reg = 15'd1920;
      height_reg = 15'd1080;
      color_reg = 32'hFFFF_FFFF;
      expected_pixels.delete();
      errors = 0;
      pending = 0;
      segments_seen = 0;
      pixels_seen = 0;
      rejects_seen = 0;
    end else begin
      if (result_valid) begin
        pixels_seen++;
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("pixel (%0d,%0d) with nothing expected",
                                    result.pixel_x, result.pixel_y));
        end else begin
          want = expected_pixels.pop_front();
          if (result.pixel_x !== want.pixel_x)
            report_mismatch($sformatf("pixel_x got %0d want %0d",
                                      result.pixel_x, want.pixel_x));
          if (result.pixel_y !== want.pixel_y)
            report_mismatch($sformatf("pixel_y got %0d want %0d",
                                      result.pixel_y, want.pixel_y));
          if (result.visible !== want.visible)
            report_mismatch($sformatf("visible got %b want %b at (%0d,%0d)",
                                      result.visible, want.visible,
                                      want.pixel_x, want.pixel_y));
          if (result.visible_count !== want.visible_count)
            report_mismatch($sformatf("visible_count got %0d want %0d",
                                      result.visible_count, want.visible_count));
          if (result.pixel_color !== want.pixel_color)
            report_mismatch($sformatf("pixel_color got %h want %h",
                                      result.pixel_color, want.pixel_color));
          if (result.too_long !== want.too_long)
            report_mismatch($sformatf("too_long got %b want %b",
                                      result.too_long, want.too_long));
          if (result.last_pixel !== want.last_pixel)
            report_mismatch($sformatf("last_pixel got %b want %b",
                                      result.last_pixel, want.last_pixel));
        end
      end
      if (start && !busy) begin
        segments_seen++;
        trace_segment(segment);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          clr_pkg::CFG_SCREEN_WIDTH:  width_reg = cfg_data[14:0];
          clr_pkg::CFG_SCREEN_HEIGHT: height_reg = cfg_data[14:0];
          clr_pkg::CFG_DRAW_COLOR:    color_reg = cfg_data;
          default: ;
        endcase
      end
      pending = expected_pixels.size();
    end
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_SEGMENTS = 360;
  localparam int PHASES = 6;
  localparam logic [1:0] CFG_SPARE = 2'd3;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  clr_pkg::segment_t segment;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [1:0]        cfg_index;
  logic [31:0]       cfg_data;
  logic              result_valid;
  clr_pkg::pixel_t   result;

  int errors, pending, segments_seen, pixels_seen, rejects_seen;
  int idle_cycles, cfg_writes, burst_left;
  int scr_w, scr_h;

  clipped_line_rasterizer_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .segment      (segment),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result       (result)
  );

  clr_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .segment       (segment),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .result_valid  (result_valid),
    .result        (result),
    .errors        (errors),
    .pending       (pending),
    .segments_seen (segments_seen),
    .pixels_seen   (pixels_seen),
    .rejects_seen  (rejects_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", idle_cycles);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic clr_pkg::segment_t make_segment(input int x0, input int y0,
                                                     input int x1, input int y1);
    clr_pkg::segment_t s;
    s.start_x = 16'(x0);
    s.start_y = 16'(y0);
    s.end_x = 16'(x1);
    s.end_y = 16'(y1);
    return s;
  endfunction

  function automatic clr_pkg::segment_t random_segment();
    clr_pkg::segment_t s;
    int span, minor, dmaj, dmin, bx, by;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 12) begin
      s = {$urandom, $urandom};
      return s;
    end
    pick = $urandom_range(99);
    if (pick < 65) span = $urandom_range(12);
    else if (pick < 90) span = $urandom_range(62, 13);
    else span = $urandom_range(64, 62);
    minor = $urandom_range(span);
    dmaj = $urandom_range(1) ? span : -span;
    dmin = $urandom_range(1) ? minor : -minor;
    if ($urandom_range(99) < 60) begin
      bx = int'($urandom_range(scr_w + 16)) - 8;
      by = int'($urandom_range(scr_h + 16)) - 8;
      if (bx > 32767 - 64) bx = 32767 - 64;
      if (by > 32767 - 64) by = 32767 - 64;
    end else begin
      bx = int'($urandom_range(65535 - 128)) - 32768 + 64;
      by = int'($urandom_range(65535 - 128)) - 32768 + 64;
    end
    if ($urandom_range(1)) s = make_segment(bx, by, bx + dmaj, by + dmin);
    else s = make_segment(bx, by, bx + dmin, by + dmaj);
    return s;
  endfunction

  function automatic int pick_gap();
    int unsigned pick;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    pick = $urandom_range(99);
    if (pick < 4) begin
      burst_left = $urandom_range(30, 10);
      return 0;
    end
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  // entered and left at a falling edge
  task automatic send_segment(input clr_pkg::segment_t s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    segment <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_writes++;
    if (idx == clr_pkg::CFG_SCREEN_WIDTH) scr_w = data[14:0];
    if (idx == clr_pkg::CFG_SCREEN_HEIGHT) scr_h = data[14:0];
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic configure(input logic [31:0] w, input logic [31:0] h,
                           input logic [31:0] colour, input bit spare);
    drain();
    if (spare) write_reg(CFG_SPARE, $urandom);
    write_reg(clr_pkg::CFG_SCREEN_WIDTH, w);
    write_reg(clr_pkg::CFG_SCREEN_HEIGHT, h);
    write_reg(clr_pkg::CFG_DRAW_COLOR, colour);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_directed();
    clr_pkg::segment_t list[$];
    list.push_back(make_segment(5, 5, 5, 5));
    list.push_back(make_segment(0, 0, 63, 0));
    list.push_back(make_segment(63, 10, 0, 10));
    list.push_back(make_segment(7, 0, 7, 63));
    list.push_back(make_segment(7, 63, 7, 0));
    list.push_back(make_segment(0, 0, 10, 10));
    list.push_back(make_segment(10, 10, 0, 0));
    list.push_back(make_segment(0, 10, 10, 0));
    list.push_back(make_segment(10, 0, 0, 10));
    list.push_back(make_segment(0, 0, 1, 2));
    list.push_back(make_segment(0, 0, 2, 1));
    list.push_back(make_segment(0, 0, 64, 0));
    list.push_back(make_segment(0, 0, 3, 64));
    list.push_back(make_segment(-32768, -32768, 32767, 32767));
    list.push_back(make_segment(32767, -32768, -32768, 32767));
    list.push_back(make_segment(-32768, -32768, -32705, -32760));
    list.push_back(make_segment(32767, 32767, 32704, 32740));
    list.push_back(make_segment(-5, -3, 10, 8));
    list.push_back(make_segment(1915, 1075, 1925, 1085));
    list.push_back(make_segment(3, -20, -2, 20));
    list.push_back(make_segment(0, -1, -1, -1));
    foreach (list[i]) send_segment(list[i]);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    segment = '0;
    cfg_valid = 1'b0;
    cfg_index = clr_pkg::CFG_SCREEN_WIDTH;
    cfg_data = '0;
    cfg_writes = 0;
    burst_left = 0;
    scr_w = 1920;
    scr_h = 1080;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_directed();
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: configure(32'd1, 32'd1, 32'd0, 1'b0);
        1: configure(32'hFFFF_FFFF, 32'h0000_7FFF, 32'hFFFF_FFFF, 1'b0);
        2: configure(32'h0000_8000, $urandom_range(200, 1), $urandom, 1'b1);
        3: configure($urandom_range(200, 1), $urandom_range(200, 1), $urandom, 1'b0);
        4: configure(32'd1920, 32'd1080, $urandom, 1'b0);
        default: configure($urandom, $urandom, $urandom, 1'b1);
      endcase
      repeat (RANDOM_SEGMENTS / PHASES) send_segment(random_segment());
    end
    drain();
    repeat (8) @(negedge clk);

    $display("covered %0d segments (%0d rejected as too long), %0d pixels checked",
             segments_seen, rejects_seen, pixels_seen);
    $display("%0d register writes across %0d screen settings", cfg_writes, PHASES + 1);
    if (pending != 0) $display("%0d expected pixels never arrived", pending);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- clipped_line_rasterizer_unit.f -----
design/clr_pkg.sv
design/clr_front.sv
design/clr_queue.sv
design/clr_walker.sv
design/clipped_line_rasterizer_unit.sv
tb/clr_checker.sv
tb/tb.sv
